@@ design/ertt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo request tracker: shared package
// Operation and status codes, port transaction types and the token that walks
// the cell chain.
// ----------------------------------------------------------------------------
package ertt_pkg;

	localparam int NOW_W  = 48;
	localparam int TMO_W  = 32;
	localparam int RTT_W  = 31;
	localparam int CFG_W  = 32;
	localparam int SLOT_W = 3;

	typedef enum logic [1:0] {
		OP_SEND  = 2'd0,
		OP_REPLY = 2'd1,
		OP_CHECK = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_SENT      = 4'd0,
		ST_NOSLOT    = 4'd1,
		ST_TXFAIL    = 4'd2,
		ST_MATCHED   = 4'd3,
		ST_UNMATCHED = 4'd4,
		ST_READY     = 4'd5,
		ST_PENDING   = 4'd6,
		ST_NOTFOUND  = 4'd7,
		ST_TIMEOUT   = 4'd8
	} status_t;

	typedef enum logic {
		REG_ECHO_ID = 1'b0,
		REG_TIMEOUT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [NOW_W-1:0] now_ticks;
		logic [15:0]      reply_identifier;
		logic [15:0]      sequence_in;
		logic             tx_ok;
	} req_t;

	typedef struct packed {
		logic [3:0]        status;
		logic [15:0]       sequence_out;
		logic [15:0]       identifier_out;
		logic [RTT_W-1:0]  round_trip;
		logic [SLOT_W-1:0] slot_index;
	} rsp_t;

	typedef struct packed {
		logic              vld;
		logic              done;
		logic [1:0]        op;
		logic [NOW_W-1:0]  now;
		logic [15:0]       rid;
		logic [15:0]       seq;
		logic              tx_ok;
		logic [15:0]       ident;
		logic [15:0]       nseq;
		logic [TMO_W-1:0]  tmo;
		status_t           status;
		logic [RTT_W-1:0]  rtt;
		logic [SLOT_W-1:0] slot;
	} tok_t;

endpackage

@@ design/ertt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo request tracker: table cell
// Holds one table entry. Serves the passing token if no earlier cell has, then
// hands it on through a register.
// ----------------------------------------------------------------------------
module ertt_cell #(
	parameter int SLOT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ertt_pkg::tok_t tok_i,
	output ertt_pkg::tok_t tok_o
);

	logic                        valid_q;
	logic                        replied_q;
	logic [15:0]                 ident_q;
	logic [15:0]                 seq_q;
	logic [ertt_pkg::NOW_W-1:0]  sent_q;
	logic [ertt_pkg::RTT_W-1:0]  rtt_q;
	ertt_pkg::tok_t              tok_q;

	logic                        live;
	logic                        hit_send;
	logic                        hit_reply;
	logic                        hit_check;
	logic                        expired;
	logic [ertt_pkg::NOW_W-1:0]  elapsed;
	logic [ertt_pkg::RTT_W-1:0]  rtt_sat;
	ertt_pkg::tok_t              tok_d;

	assign live      = tok_i.vld && !tok_i.done;
	assign hit_send  = live && (tok_i.op == ertt_pkg::OP_SEND) && !valid_q;
	assign hit_reply = live && (tok_i.op == ertt_pkg::OP_REPLY) && valid_q &&
		(ident_q == tok_i.rid) && (seq_q == tok_i.seq);
	assign hit_check = live && (tok_i.op == ertt_pkg::OP_CHECK) && valid_q &&
		(seq_q == tok_i.seq);

	assign elapsed = tok_i.now - sent_q;
	assign expired = elapsed >= {{(ertt_pkg::NOW_W-ertt_pkg::TMO_W){1'b0}}, tok_i.tmo};
	assign rtt_sat = (elapsed[ertt_pkg::NOW_W-1:ertt_pkg::RTT_W] != '0) ?
		{ertt_pkg::RTT_W{1'b1}} : elapsed[ertt_pkg::RTT_W-1:0];

	always_comb begin
		tok_d = tok_i;
		if (hit_send) begin
			tok_d.done   = 1'b1;
			tok_d.status = tok_i.tx_ok ? ertt_pkg::ST_SENT : ertt_pkg::ST_TXFAIL;
			tok_d.slot   = ertt_pkg::SLOT_W'(SLOT);
		end else if (hit_reply) begin
			tok_d.done   = 1'b1;
			tok_d.status = ertt_pkg::ST_MATCHED;
			tok_d.slot   = ertt_pkg::SLOT_W'(SLOT);
		end else if (hit_check) begin
			tok_d.done = 1'b1;
			if (replied_q) begin
				tok_d.status = ertt_pkg::ST_READY;
				tok_d.rtt    = rtt_q;
				tok_d.slot   = ertt_pkg::SLOT_W'(SLOT);
			end else if (expired) begin
				tok_d.status = ertt_pkg::ST_TIMEOUT;
				tok_d.slot   = ertt_pkg::SLOT_W'(SLOT);
			end else begin
				tok_d.status = ertt_pkg::ST_PENDING;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			replied_q <= 1'b0;
		end else if (hit_send) begin
			valid_q   <= tok_i.tx_ok;
			replied_q <= 1'b0;
		end else if (hit_reply) begin
			replied_q <= 1'b1;
		end else if (hit_check && (replied_q || expired)) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_send) begin
			ident_q <= tok_i.ident;
			seq_q   <= tok_i.nseq;
			sent_q  <= tok_i.now;
		end
		if (hit_reply) begin
			rtt_q <= rtt_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

@@ design/echo_request_tracker_table_top.sv @@
`timescale 1ns / 1ps
// Flow: an accepted request is registered into the first token register, then
// walks the cell row one cell per cycle; the result strobe comes as it leaves the last cell.
// Only one transaction is in flight at a time; busy drops the cycle
// after the strobe. The receiver cannot stall, so the strobe is never held.
// Reset: all entries free, sequence 1, identifier 1, timeout 1000 ticks.
// ----------------------------------------------------------------------------
// Echo request tracker table: top level
// Pending echo request table built as a row of entry cells with a token that
// carries each transaction from the first slot to the last.
// ----------------------------------------------------------------------------
module echo_request_tracker_table_top #(
	parameter int ENTRIES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  ertt_pkg::req_t             req,
	output logic                       done,
	output ertt_pkg::rsp_t             result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  ertt_pkg::reg_idx_t         cfg_index,
	input  logic [ertt_pkg::CFG_W-1:0] cfg_data
);

	logic                       busy_q;
	logic [15:0]                next_seq_q;
	logic [15:0]                ident_q;
	logic [ertt_pkg::TMO_W-1:0] tmo_q;
	ertt_pkg::tok_t             tok0_q;
	ertt_pkg::tok_t             tok [ENTRIES+1];
	logic [ENTRIES:0]           tok_vld;
	logic                       accept;
	ertt_pkg::tok_t             fin;
	logic                       issued;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= 16'd1;
			tmo_q   <= ertt_pkg::TMO_W'(1000);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ertt_pkg::REG_ECHO_ID: ident_q <= cfg_data[15:0];
				ertt_pkg::REG_TIMEOUT: tmo_q   <= cfg_data[ertt_pkg::TMO_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q <= '0;
		end else begin
			tok0_q.vld <= accept;
			if (accept) begin
				tok0_q.done   <= 1'b0;
				tok0_q.op     <= req.operation;
				tok0_q.now    <= req.now_ticks;
				tok0_q.rid    <= req.reply_identifier;
				tok0_q.seq    <= req.sequence_in;
				tok0_q.tx_ok  <= req.tx_ok;
				tok0_q.ident  <= ident_q;
				tok0_q.nseq   <= next_seq_q;
				tok0_q.tmo    <= tmo_q;
				tok0_q.status <= ertt_pkg::ST_NOTFOUND;
				tok0_q.rtt    <= '0;
				tok0_q.slot   <= '0;
			end
		end
	end

	assign tok[0] = tok0_q;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		ertt_cell #(
			.SLOT(g)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.tok_i (tok[g]),
			.tok_o (tok[g+1])
		);
	end

	for (genvar g = 0; g <= ENTRIES; g++) begin : g_vld
		assign tok_vld[g] = tok[g].vld;
	end

	assign fin    = tok[ENTRIES];
	assign done   = fin.vld;
	assign issued = fin.done &&
		((fin.status == ertt_pkg::ST_SENT) || (fin.status == ertt_pkg::ST_TXFAIL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			next_seq_q <= 16'd1;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin.vld) begin
				busy_q <= 1'b0;
			end
			if (fin.vld && issued) begin
				next_seq_q <= next_seq_q + 16'd1;
			end
		end
	end

	always_comb begin
		result = '0;
		if (fin.done) begin
			result.status     = fin.status;
			result.round_trip = fin.rtt;
			result.slot_index = fin.slot;
			if (issued) begin
				result.sequence_out   = fin.nseq;
				result.identifier_out = fin.ident;
			end
		end else begin
			case (fin.op)
				ertt_pkg::OP_SEND:  result.status = ertt_pkg::ST_NOSLOT;
				ertt_pkg::OP_REPLY: result.status = ertt_pkg::ST_UNMATCHED;
				default:            result.status = ertt_pkg::ST_NOTFOUND;
			endcase
		end
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("result strobe with no transaction in flight");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one transaction in the cell row");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe on consecutive cycles");

	a_accept_token: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (tok_vld[0] && busy_q))
		else $error("accepted transaction did not enter the cell row");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo request tracker table: testbench
// Drives send, reply and check transactions through the command port and
// predicts every result from a local copy of the slot table, the sequence
// counter and the two registers. Directed tests cover reset defaults, repeated
// replies, a full table, refused transmits, tick wrap, round-trip saturation
// and both timeout extremes. Random phases follow, each with its own register
// settings and idle pattern.
// ----------------------------------------------------------------------------
module tb_top;
	import ertt_pkg::*;

	localparam int ENTRIES = 8;
	localparam int CYCLE_LIMIT = 100000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             req;
	logic             done;
	rsp_t             result;
	logic             cfg_valid;
	logic             cfg_ready;
	reg_idx_t         cfg_index;
	logic [CFG_W-1:0] cfg_data;

	echo_request_tracker_table_top #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// local copy of the slot table
	logic              tbl_valid   [ENTRIES];
	logic              tbl_replied [ENTRIES];
	logic [15:0]       tbl_ident   [ENTRIES];
	logic [15:0]       tbl_seq     [ENTRIES];
	logic [NOW_W-1:0]  tbl_sent    [ENTRIES];
	logic [RTT_W-1:0]  tbl_rtt     [ENTRIES];
	logic [15:0]       tbl_next_seq;
	logic [15:0]       cfg_echo_id;
	logic [TMO_W-1:0]  cfg_timeout;

	rsp_t              awaited_results[$];
	int                fault_count;
	int                op_count[4];
	int                reg_writes;
	int                max_gap;
	int                cycle_count;
	logic [NOW_W-1:0]  tick_now;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaited_results.size());
			$display("FAIL echo_request_tracker_table_top");
			$finish;
		end
	end

	function automatic rsp_t track_request(req_t r);
		rsp_t             o;
		int               hit;
		int               i;
		logic [NOW_W-1:0] age;
		o        = '0;
		hit      = -1;
		o.status = ST_NOTFOUND;
		case (r.operation)
			OP_SEND: begin
				for (i = ENTRIES - 1; i >= 0; i--)
					if (!tbl_valid[i])
						hit = i;
				if (hit < 0) begin
					o.status = ST_NOSLOT;
				end else begin
					tbl_ident[hit]   = cfg_echo_id;
					tbl_seq[hit]     = tbl_next_seq;
					tbl_sent[hit]    = r.now_ticks;
					tbl_replied[hit] = 1'b0;
					tbl_valid[hit]   = r.tx_ok;
					o.status         = r.tx_ok ? ST_SENT : ST_TXFAIL;
					o.sequence_out   = tbl_next_seq;
					o.identifier_out = cfg_echo_id;
					o.slot_index     = hit[SLOT_W-1:0];
					tbl_next_seq     = tbl_next_seq + 16'd1;
				end
			end
			OP_REPLY: begin
				for (i = ENTRIES - 1; i >= 0; i--)
					if (tbl_valid[i] && tbl_ident[i] == r.reply_identifier &&
					    tbl_seq[i] == r.sequence_in)
						hit = i;
				if (hit < 0) begin
					o.status = ST_UNMATCHED;
				end else begin
					age = r.now_ticks - tbl_sent[hit];
					tbl_rtt[hit] = (age > 48'h7FFF_FFFF) ? 31'h7FFF_FFFF : age[RTT_W-1:0];
					tbl_replied[hit] = 1'b1;
					o.status     = ST_MATCHED;
					o.slot_index = hit[SLOT_W-1:0];
				end
			end
			OP_CHECK: begin
				for (i = ENTRIES - 1; i >= 0; i--)
					if (tbl_valid[i] && tbl_seq[i] == r.sequence_in)
						hit = i;
				if (hit >= 0) begin
					age = r.now_ticks - tbl_sent[hit];
					if (tbl_replied[hit]) begin
						tbl_valid[hit] = 1'b0;
						o.status     = ST_READY;
						o.round_trip = tbl_rtt[hit];
						o.slot_index = hit[SLOT_W-1:0];
					end else if (age >= {16'd0, cfg_timeout}) begin
						tbl_valid[hit] = 1'b0;
						o.status     = ST_TIMEOUT;
						o.slot_index = hit[SLOT_W-1:0];
					end else begin
						o.status = ST_PENDING;
					end
				end
			end
			default: o.status = ST_NOTFOUND;
		endcase
		return o;
	endfunction

	function automatic req_t make_req(logic [1:0] op, logic [NOW_W-1:0] now,
		logic [15:0] rid, logic [15:0] seq, logic tx);
		req_t r;
		r.operation        = op;
		r.now_ticks        = now;
		r.reply_identifier = rid;
		r.sequence_in      = seq;
		r.tx_ok            = tx;
		return r;
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: st=%0d seq=%0d id=%0d rtt=%0d slot=%0d",
						result.status, result.sequence_out, result.identifier_out,
						result.round_trip, result.slot_index);
			end else begin
				want = awaited_results.pop_front();
				if (result.status !== want.status ||
				    result.sequence_out !== want.sequence_out ||
				    result.identifier_out !== want.identifier_out ||
				    result.round_trip !== want.round_trip ||
				    result.slot_index !== want.slot_index) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("mismatch: expected st=%0d seq=%0d id=%0d rtt=%0d slot=%0d",
							want.status, want.sequence_out, want.identifier_out,
							want.round_trip, want.slot_index);
						$display("          actual   st=%0d seq=%0d id=%0d rtt=%0d slot=%0d",
							result.status, result.sequence_out, result.identifier_out,
							result.round_trip, result.slot_index);
					end
				end
			end
		end
	end

	// entered and left at a falling edge; start stays high across back-to-back items
	task automatic issue_request(req_t r);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		awaited_results.push_back(track_request(r));
		op_count[r.operation]++;
		@(negedge clk);
	endtask

	task automatic write_register(reg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_ECHO_ID)
			cfg_echo_id = val[15:0];
		else
			cfg_timeout = val;
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle_table();
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (ENTRIES + 4) @(negedge clk);
	endtask

	task automatic test_reset_defaults();
		issue_request(make_req(OP_SEND,  48'd100,  16'd0, 16'd0, 1'b1));
		issue_request(make_req(OP_CHECK, 48'd200,  16'd0, 16'd1, 1'b0));
		issue_request(make_req(OP_REPLY, 48'd350,  16'd1, 16'd1, 1'b0));
		// second reply overwrites the stored round trip
		issue_request(make_req(OP_REPLY, 48'd400,  16'd1, 16'd1, 1'b0));
		// replied entry reports ready although the timeout has passed
		issue_request(make_req(OP_CHECK, 48'd5000, 16'd0, 16'd1, 1'b0));
		issue_request(make_req(OP_CHECK, 48'd5001, 16'd0, 16'd1, 1'b0));
		issue_request(make_req(OP_UNUSED, '1, '1, '1, 1'b1));
	endtask

	task automatic test_table_full();
		int i;
		issue_request(make_req(OP_SEND, 48'd10, 16'd0, 16'd0, 1'b0));
		for (i = 0; i < ENTRIES; i++)
			issue_request(make_req(OP_SEND, 48'hFFFF_FFFF_FF00, '1, '1, 1'b1));
		issue_request(make_req(OP_SEND, 48'hFFFF_FFFF_FF08, 16'd0, 16'd0, 1'b1));
		// tick count wraps between send and check
		issue_request(make_req(OP_CHECK, 48'h10, 16'd0, 16'd5, 1'b0));
		issue_request(make_req(OP_REPLY, 48'h20, 16'd1, 16'd5, 1'b0));
		issue_request(make_req(OP_CHECK, 48'h28, 16'd0, 16'd5, 1'b0));
		issue_request(make_req(OP_SEND,  48'h30, 16'd0, 16'd0, 1'b1));
	endtask

	task automatic test_timeout_limits();
		settle_table();
		write_register(REG_TIMEOUT, 32'd0);
		write_register(REG_ECHO_ID, 32'h0000_FFFF);
		issue_request(make_req(OP_CHECK, 48'h40, 16'd0, 16'd3, 1'b0));
		issue_request(make_req(OP_SEND,  48'h50, 16'd0, 16'd0, 1'b1));
		// elapsed ticks far beyond 31 bits
		issue_request(make_req(OP_REPLY, 48'h0001_0000_0000, 16'd1, 16'd4, 1'b0));
		issue_request(make_req(OP_CHECK, 48'h0001_0000_0001, 16'd0, 16'd4, 1'b0));
		settle_table();
		write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
		write_register(REG_ECHO_ID, 32'd0);
		issue_request(make_req(OP_CHECK, 48'h50 + 48'hFFFF_FFFE, 16'd0, 16'd12, 1'b0));
		issue_request(make_req(OP_CHECK, 48'h50 + 48'hFFFF_FFFF, 16'd0, 16'd12, 1'b0));
	endtask

	task automatic test_random_traffic();
		req_t             r;
		int               phase;
		int               n;
		int               pick;
		int               slot;
		int               i;
		int               live[$];
		logic [NOW_W-1:0] advance;
		logic [TMO_W-1:0] tmo;
		for (phase = 0; phase < 6; phase++) begin
			settle_table();
			case (phase)
				0: begin
					write_register(REG_ECHO_ID, 32'd0);
					write_register(REG_TIMEOUT, 32'd0);
				end
				1: begin
					write_register(REG_ECHO_ID, 32'h0000_FFFF);
					write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
				end
				default: begin
					case ($urandom_range(0, 3))
						0: tmo = 32'd1;
						1: tmo = $urandom_range(1, 3000);
						2: tmo = $urandom;
						default: tmo = $urandom_range(100, 800);
					endcase
					write_register(REG_ECHO_ID, {16'd0, 16'($urandom)});
					write_register(REG_TIMEOUT, tmo);
				end
			endcase
			max_gap = (phase == 2 || phase == 5) ? 0 : 10;
			for (n = 0; n < 75; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					advance = NOW_W'($urandom_range(0, 1500));
				else if (pick < 85)
					advance = NOW_W'($urandom_range(0, 4000));
				else if (pick < 95)
					advance = {16'd0, 32'($urandom)};
				else
					advance = {16'($urandom), 32'($urandom)};
				tick_now = tick_now + advance;
				live.delete();
				for (i = 0; i < ENTRIES; i++)
					if (tbl_valid[i])
						live.push_back(i);
				slot = (live.size() != 0) ? live[$urandom_range(0, live.size() - 1)] : -1;
				r.now_ticks        = tick_now;
				r.reply_identifier = 16'($urandom);
				r.sequence_in      = 16'($urandom);
				r.tx_ok            = ($urandom_range(0, 6) != 0);
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					r.operation = OP_SEND;
				end else if (pick < 55) begin
					r.operation = OP_REPLY;
					if (slot >= 0 && $urandom_range(0, 9) != 0) begin
						r.reply_identifier = tbl_ident[slot];
						r.sequence_in      = tbl_seq[slot];
					end
				end else if (pick < 85) begin
					r.operation = OP_CHECK;
					if (slot >= 0 && $urandom_range(0, 9) != 0)
						r.sequence_in = tbl_seq[slot];
				end else begin
					r.operation = 2'($urandom_range(0, 3));
					r.now_ticks = {16'($urandom), 32'($urandom)};
				end
				issue_request(r);
			end
		end
	endtask

	initial begin
		int i;
		arst_n      = 1'b0;
		start       = 1'b0;
		req         = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_ECHO_ID;
		cfg_data    = '0;
		fault_count = 0;
		reg_writes  = 0;
		cycle_count = 0;
		max_gap     = 10;
		tick_now    = '0;
		for (i = 0; i < 4; i++)
			op_count[i] = 0;
		for (i = 0; i < ENTRIES; i++) begin
			tbl_valid[i]   = 1'b0;
			tbl_replied[i] = 1'b0;
			tbl_ident[i]   = '0;
			tbl_seq[i]     = '0;
			tbl_sent[i]    = '0;
			tbl_rtt[i]     = '0;
		end
		tbl_next_seq = 16'd1;
		cfg_echo_id  = 16'd1;
		cfg_timeout  = 32'd1000;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_reset_defaults();
		test_table_full();
		test_timeout_limits();
		test_random_traffic();
		settle_table();
		fault_count += awaited_results.size();

		$display("ran %0d sends, %0d replies, %0d checks, %0d unused-opcode items",
			op_count[OP_SEND], op_count[OP_REPLY], op_count[OP_CHECK], op_count[OP_UNUSED]);
		$display("with %0d register writes over %0d cycles, %0d faults",
			reg_writes, cycle_count, fault_count);
		if (fault_count == 0)
			$display("PASS echo_request_tracker_table_top");
		else
			$display("FAIL echo_request_tracker_table_top");
		$finish;
	end

endmodule

@@ sim.f @@
design/ertt_pkg.sv
design/ertt_cell.sv
design/echo_request_tracker_table_top.sv
test/tb_top.sv
